// File: src/fmpf_pkg.sv
// ---------------------------------------------------------------------------
// fmpf_pkg: shared types and constants of the prefix filter
// Entry layout of the rule table, item kinds, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmpf_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;

    // item kinds on the request channel
    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // one stored rule
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              deny;
    } rule_entry_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic write;
        logic start;
        logic scan;
        logic capture;
        logic load;
    } fmpf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hit;
        logic exhausted;
    } fmpf_status_t;

    // leading-ones mask, lengths above the address width give all ones
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

`default_nettype wire

// File: src/fmpf_req_if.sv
// ---------------------------------------------------------------------------
// fmpf_req_if: request channel
// Valid/ready channel carrying add and query items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fmpf_req_if;

    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [fmpf_pkg::ADDR_W-1:0] address;
    logic [fmpf_pkg::LEN_W-1:0]  prefix_len;
    logic                        deny;

    modport source (output valid, output kind, output address, output prefix_len,
                    output deny, input ready);
    modport sink   (input valid, input kind, input address, input prefix_len,
                    input deny, output ready);

endinterface

`default_nettype wire

// File: src/fmpf_rsp_if.sv
// ---------------------------------------------------------------------------
// fmpf_rsp_if: response channel
// Valid/ready channel carrying the answer to a query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fmpf_rsp_if;

    logic valid;
    logic ready;
    logic denied;

    modport source (output valid, output denied, input ready);
    modport sink   (input valid, input denied, output ready);

endinterface

`default_nettype wire

// File: src/fmpf_ram.sv
// ---------------------------------------------------------------------------
// fmpf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/fmpf_dp.sv
// ---------------------------------------------------------------------------
// fmpf_dp: rule table and match datapath
// Appends rules, walks the table one entry a cycle for a query and holds
// the answer and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmpf_dp #(
    parameter int MAX_RULES = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fmpf_pkg::fmpf_cmd_t         cmd,
    output fmpf_pkg::fmpf_status_t           status,
    input  wire logic [fmpf_pkg::ADDR_W-1:0] address,
    input  wire logic [fmpf_pkg::LEN_W-1:0]  prefix_len,
    input  wire logic                        deny,
    output logic                             denied
);

    import fmpf_pkg::*;

    localparam int IDX_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W   = $clog2(MAX_RULES + 1);
    localparam int ENTRY_W = $bits(rule_entry_t);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pending_reg, pending_next;
    logic [ADDR_W-1:0] query_reg;
    logic              answer_reg;
    logic              denied_reg;

    logic              wr_en;
    logic              rd_en;
    rule_entry_t       wr_entry;
    rule_entry_t       rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic              match;

    // rule table
    fmpf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RULES),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // append, scan walk and prefix compare
    always_comb
    begin
        wr_entry.address = address;
        wr_entry.length  = prefix_len;
        wr_entry.deny    = deny;
        rd_entry         = rd_data;

        wr_en = cmd.write && (count_reg < CNT_W'(MAX_RULES));
        rd_en = cmd.scan && (idx_reg < count_reg);

        count_next = wr_en ? count_reg + CNT_W'(1) : count_reg;

        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (rd_en)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
        pending_next = rd_en;

        match = ((rd_entry.address ^ query_reg) & prefix_mask(rd_entry.length)) == '0;
        status.hit       = pending_reg && match;
        status.exhausted = !pending_reg && (idx_reg >= count_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pending_reg <= pending_next;
        end
    end

    // query address, answer and output register
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg <= address;
        end
        if (cmd.capture)
        begin
            answer_reg <= status.hit ? rd_entry.deny : 1'b0;
        end
        if (cmd.load)
        begin
            denied_reg <= answer_reg;
        end
    end

    assign denied = denied_reg;

    // the fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("rule count beyond table size");

    // read data marked valid only after a read was issued
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> idx_reg != '0)
        else $error("pending read without an issued index");

    // appends and scans never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write && cmd.scan))
        else $error("append during a scan");

endmodule

`default_nettype wire

// File: src/fmpf_ctrl.sv
// ---------------------------------------------------------------------------
// fmpf_ctrl: filter controller
// Accepts items, runs a scan per query and hands the answer to the output
// register once that is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmpf_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_kind,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire fmpf_pkg::fmpf_status_t status,
    output fmpf_pkg::fmpf_cmd_t         cmd
);

    import fmpf_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == KIND_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.exhausted)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // a finished scan always goes on to the load state to hand over its answer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_LOAD)
        else $error("capture not followed by load state");

    // a query transfer always starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == S_SCAN && cmd.scan)
        else $error("query did not start a scan");

endmodule

`default_nettype wire

// File: src/first_match_ip_prefix_filter_top.sv
// ---------------------------------------------------------------------------
// first_match_ip_prefix_filter_top: first-match IPv4 prefix filter
//
// Request channel req carries add and query items; response channel rsp
// carries one answer bit per query (1 denied, 0 allowed). Adds give no
// response; an add to a full table is dropped.
//
// An add is written to the table as it is taken. A query walks the rule
// table in arrival order, one entry per cycle through the table RAM's
// registered read port, and stops at the first matching prefix. It
// occupies the block from its start through the scan until its answer
// is loaded. The answer sits in an output register, so a stalled
// receiver delays only the hand-over of the next answer, and the request
// side is taken again once the answer is in that register.
//
// Reset empties the table (fill count to zero); no clearing pass is
// needed. An empty table or a query with no match answers allow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_match_ip_prefix_filter_top #(
    parameter int MAX_RULES = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fmpf_req_if.sink    req,
    fmpf_rsp_if.source  rsp
);

    import fmpf_pkg::*;

    fmpf_cmd_t    cmd;
    fmpf_status_t status;

    // controller
    fmpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    fmpf_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .address    (req.address),
        .prefix_len (req.prefix_len),
        .deny       (req.deny),
        .denied     (rsp.denied)
    );

endmodule

`default_nettype wire
